[design/pbp_pkg.sv]
package pbp_pkg;

  localparam int unsigned FramesDefault = 32;
  localparam int unsigned MaxTablesDefault = 10;
  localparam int unsigned CfgW = 6;
  localparam int unsigned ActW = 3;
  localparam int unsigned TblW = 4;
  localparam int unsigned PageW = 32;
  localparam int unsigned StatW = 4;
  localparam int unsigned FrIdxW = 5;
  localparam int unsigned PinW = 8;
  localparam logic [CfgW-1:0] CfgReset = 6'd32;
  localparam logic [PinW-1:0] PinMax = 8'd255;

  typedef enum logic [ActW-1:0] {
    ACT_FETCH = 3'd0,
    ACT_UNPIN = 3'd1,
    ACT_UNPIN_DIRTY = 3'd2,
    ACT_CLOSE = 3'd3,
    ACT_FLUSH = 3'd4
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_HIT = 4'd0,
    ST_FILLED = 4'd1,
    ST_EVICT_CLEAN = 4'd2,
    ST_EVICT_DIRTY = 4'd3,
    ST_ALL_PINNED = 4'd4,
    ST_UNPINNED = 4'd5,
    ST_NOT_RESIDENT = 4'd6,
    ST_WRITEBACK = 4'd7,
    ST_DONE = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE,
    S_VICTIM,
    S_WALK
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // latch the input beat
    logic match;       // mark the tag compare state
    logic do_fetch;    // apply fetch outcome and emit
    logic do_unpin;    // apply unpin and emit
    logic scan_clr;    // reset victim/walk pointer, register tag match result
    logic scan_step;   // one frame of victim search
    logic walk_step;   // one frame of close/flush walk
    logic emit_done;   // emit a plain done
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic bad_tbl;
    logic hit;
    logic can_fill;
    logic scan_last;
    logic walk_last;
  } sts_t;

endpackage

[design/page_buffer_pool_lru_pin_unit.sv]
// Channel   Direction  Handshake               Payload
// command   in         start_i, busy_o         action_i, table_ident_i, page_number_i
// result    out        result_valid_o strobe   status_o, frame_index_o, victim_table_o,
//                                              victim_page_o, last_result_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (frames_in_use)
//
// A command is taken when start_i is high and busy_o is low; one at a time.
// Unpins and fetches that hit, fill or name a bad table pass through the match
// and decide states and then strobe their registered result; unused action codes
// strobe a done beat from the match state. A fetch that must evict first scans
// every frame, one per cycle. Close-table and flush-all walk every frame once,
// one per cycle, strobe one write-back beat per dirty frame that they cover and
// a final done beat.
// Reset empties the pool at once. Results cannot be stalled.
module page_buffer_pool_lru_pin_unit
  import pbp_pkg::*;
#(
  parameter int unsigned Frames = FramesDefault,
  parameter int unsigned MaxTables = MaxTablesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [ActW-1:0]   action_i,
  input  logic [TblW-1:0]   table_ident_i,
  input  logic [PageW-1:0]  page_number_i,
  output logic              result_valid_o,
  output logic [StatW-1:0]  status_o,
  output logic [FrIdxW-1:0] frame_index_o,
  output logic [TblW-1:0]   victim_table_o,
  output logic [PageW-1:0]  victim_page_o,
  output logic              last_result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgW-1:0]   cfg_data_i
);

  ctl_t ctl;
  sts_t sts;
  logic [CfgW-1:0] fiu_q;

  // The limit register takes a beat only while no command is running or starting.
  assign cfg_ready_o = !busy_o && !start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fiu_q <= cfg_data_i;
    end
  end

  pbp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .sts_i    (sts),
    .ctl_o    (ctl),
    .busy_o   (busy_o)
  );

  pbp_dp #(
    .Frames    (Frames),
    .MaxTables (MaxTables)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .action_i        (action_i),
    .table_ident_i   (table_ident_i),
    .page_number_i   (page_number_i),
    .frames_in_use_i (fiu_q),
    .sts_o           (sts),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .frame_index_o   (frame_index_o),
    .victim_table_o  (victim_table_o),
    .victim_page_o   (victim_page_o),
    .last_result_o   (last_result_o)
  );

endmodule

[design/pbp_ctrl.sv]
module pbp_ctrl
  import pbp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ActW-1:0] action_i,
  input  sts_t            sts_i,
  output ctl_t            ctl_o,
  output logic            busy_o
);

  state_e state_q, state_d;
  logic [ActW-1:0] act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q <= '0;
    end else begin
      state_q <= state_d;
      if (start_i && state_q == S_IDLE) begin
        act_q <= action_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    busy_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.capture = 1'b1;
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        ctl_o.match = 1'b1;
        ctl_o.scan_clr = 1'b1;
        if (act_q == ACT_CLOSE || act_q == ACT_FLUSH) begin
          state_d = S_WALK;
        end else if (act_q == ACT_FETCH || act_q == ACT_UNPIN ||
                     act_q == ACT_UNPIN_DIRTY) begin
          state_d = S_DECIDE;
        end else begin
          ctl_o.emit_done = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DECIDE: begin
        if (act_q == ACT_FETCH) begin
          if (sts_i.bad_tbl || sts_i.hit || sts_i.can_fill) begin
            ctl_o.do_fetch = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_VICTIM;
          end
        end else begin
          ctl_o.do_unpin = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_VICTIM: begin
        if (sts_i.scan_last) begin
          ctl_o.do_fetch = 1'b1;
          state_d = S_IDLE;
        end else begin
          ctl_o.scan_step = 1'b1;
        end
      end
      S_WALK: begin
        ctl_o.walk_step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.do_fetch && ctl_o.do_unpin)) else $error("two commands");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("busy not raised");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !(ctl_o.walk_step || ctl_o.scan_step)) else $error("idle work");
`endif

endmodule

[design/pbp_dp.sv]
module pbp_dp
  import pbp_pkg::*;
#(
  parameter int unsigned Frames = FramesDefault,
  parameter int unsigned MaxTables = MaxTablesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  input  logic [ActW-1:0]   action_i,
  input  logic [TblW-1:0]   table_ident_i,
  input  logic [PageW-1:0]  page_number_i,
  input  logic [CfgW-1:0]   frames_in_use_i,
  output sts_t              sts_o,
  output logic              result_valid_o,
  output logic [StatW-1:0]  status_o,
  output logic [FrIdxW-1:0] frame_index_o,
  output logic [TblW-1:0]   victim_table_o,
  output logic [PageW-1:0]  victim_page_o,
  output logic              last_result_o
);

  localparam int unsigned IdxW = (Frames > 1) ? $clog2(Frames) : 1;
  localparam int unsigned CntW = $clog2(Frames + 1);

  logic [Frames-1:0]    valid_q, dirty_q;
  logic [TblW-1:0]      tbl_q [Frames];
  logic [PageW-1:0]     page_q [Frames];
  logic [PinW-1:0]      pins_q [Frames];
  logic [IdxW-1:0]      rank_q [Frames];
  logic [CntW-1:0]      filled_q;

  logic [ActW-1:0]      act_q;
  logic [TblW-1:0]      in_tbl_q;
  logic [PageW-1:0]     in_page_q;
  logic                 hit_q;
  logic [IdxW-1:0]      hit_idx_q;

  logic [IdxW:0]        ptr_q;
  logic                 vfound_q;
  logic [IdxW-1:0]      vidx_q;

  logic                 rv_q, rv_d, last_q;
  logic [StatW-1:0]     st_q;
  logic [FrIdxW-1:0]    fr_q;
  logic [TblW-1:0]      vt_q;
  logic [PageW-1:0]     vp_q;

  logic [Frames-1:0]    match_c;
  logic                 hit_c;
  logic [IdxW-1:0]      hit_idx_c;
  logic [CntW-1:0]      lim_c;
  logic                 bad_c;
  logic [IdxW-1:0]      ptr_idx;
  logic                 walk_end;

  assign ptr_idx = ptr_q[IdxW-1:0];
  assign bad_c = (in_tbl_q == '0) || (in_tbl_q > TblW'(MaxTables));

  always_comb begin
    if (frames_in_use_i == '0) begin
      lim_c = CntW'(1);
    end else if ({26'd0, frames_in_use_i} > 32'(Frames)) begin
      lim_c = CntW'(Frames);
    end else begin
      lim_c = CntW'(frames_in_use_i);
    end
  end

  // Associative tag compare, one comparator per frame.
  always_comb begin
    hit_c = 1'b0;
    hit_idx_c = '0;
    for (int i = 0; i < Frames; i++) begin
      match_c[i] = valid_q[i] && tbl_q[i] == in_tbl_q && page_q[i] == in_page_q;
    end
    for (int i = Frames - 1; i >= 0; i--) begin
      if (match_c[i]) begin
        hit_c = 1'b1;
        hit_idx_c = IdxW'(i);
      end
    end
  end

  // The walk visits frames 0 to Frames-1 and spends one more step on the done beat.
  assign walk_end = (ptr_q == (IdxW+1)'(Frames));

  assign sts_o.bad_tbl = bad_c;
  assign sts_o.hit = hit_q;
  assign sts_o.can_fill = filled_q < lim_c;
  assign sts_o.scan_last = (ptr_q == (IdxW+1)'(Frames));
  assign sts_o.walk_last = walk_end;

  // Touch helper: rank of frame f goes to 0, younger valid frames age by one.
  logic           tch_en;
  logic [IdxW-1:0] tch_f;
  logic [IdxW:0]   tch_r;
  logic           walk_sel;

  always_comb begin
    tch_en = 1'b0;
    tch_f = '0;
    tch_r = '0;
    if (ctl_i.do_fetch && !bad_c) begin
      if (hit_q) begin
        tch_en = 1'b1;
        tch_f = hit_idx_q;
        tch_r = {1'b0, rank_q[hit_idx_q]};
      end else if (filled_q < lim_c) begin
        tch_en = 1'b1;
        tch_f = IdxW'(filled_q);
        tch_r = (IdxW+1)'(Frames);
      end else if (vfound_q) begin
        tch_en = 1'b1;
        tch_f = vidx_q;
        tch_r = {1'b0, rank_q[vidx_q]};
      end
    end
    walk_sel = ctl_i.walk_step && !walk_end && valid_q[ptr_idx] &&
               (act_q == ACT_FLUSH || tbl_q[ptr_idx] == in_tbl_q);
  end

  assign rv_d = ctl_i.do_fetch || ctl_i.do_unpin || ctl_i.emit_done ||
                (ctl_i.walk_step && ((walk_sel && dirty_q[ptr_idx]) || walk_end));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      filled_q <= '0;
      rv_q <= 1'b0;
      ptr_q <= '0;
      vfound_q <= 1'b0;
      for (int i = 0; i < Frames; i++) begin
        pins_q[i] <= '0;
        rank_q[i] <= '0;
      end
    end else begin
      rv_q <= rv_d;
      if (ctl_i.scan_clr) begin
        ptr_q <= '0;
        vfound_q <= 1'b0;
      end
      if (ctl_i.scan_step) begin
        ptr_q <= ptr_q + 1'b1;
        if (valid_q[ptr_idx] && pins_q[ptr_idx] == '0 &&
            (!vfound_q || rank_q[ptr_idx] > rank_q[vidx_q])) begin
          vfound_q <= 1'b1;
        end
      end
      if (tch_en) begin
        for (int i = 0; i < Frames; i++) begin
          if (IdxW'(i) != tch_f && valid_q[i] && {1'b0, rank_q[i]} < tch_r) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
        rank_q[tch_f] <= '0;
      end
      if (ctl_i.do_fetch) begin
        if (!bad_c && hit_q) begin
          if (pins_q[hit_idx_q] != PinMax) begin
            pins_q[hit_idx_q] <= pins_q[hit_idx_q] + 1'b1;
          end
        end else if (!bad_c && filled_q < lim_c) begin
          filled_q <= filled_q + 1'b1;
          valid_q[IdxW'(filled_q)] <= 1'b1;
          dirty_q[IdxW'(filled_q)] <= 1'b0;
          pins_q[IdxW'(filled_q)] <= PinW'(1);
        end else if (!bad_c && vfound_q) begin
          dirty_q[vidx_q] <= 1'b0;
          pins_q[vidx_q] <= PinW'(1);
        end
      end
      if (ctl_i.do_unpin) begin
        if (hit_q) begin
          if (pins_q[hit_idx_q] != '0) begin
            pins_q[hit_idx_q] <= pins_q[hit_idx_q] - 1'b1;
          end
          if (act_q == ACT_UNPIN_DIRTY) begin
            dirty_q[hit_idx_q] <= 1'b1;
          end
        end
      end
      if (ctl_i.walk_step) begin
        ptr_q <= ptr_q + 1'b1;
        if (walk_sel) begin
          dirty_q[ptr_idx] <= 1'b0;
          if (act_q == ACT_CLOSE) begin
            pins_q[ptr_idx] <= '0;
          end
        end
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      act_q <= action_i;
      in_tbl_q <= table_ident_i;
      in_page_q <= page_number_i;
    end
    if (ctl_i.scan_clr) begin
      hit_q <= hit_c;
      hit_idx_q <= hit_idx_c;
    end
    if (ctl_i.scan_step && valid_q[ptr_idx] && pins_q[ptr_idx] == '0 &&
        (!vfound_q || rank_q[ptr_idx] > rank_q[vidx_q])) begin
      vidx_q <= ptr_idx;
    end
    if (ctl_i.do_fetch && !bad_c && !hit_q) begin
      if (filled_q < lim_c) begin
        tbl_q[IdxW'(filled_q)] <= in_tbl_q;
        page_q[IdxW'(filled_q)] <= in_page_q;
      end else if (vfound_q) begin
        tbl_q[vidx_q] <= in_tbl_q;
        page_q[vidx_q] <= in_page_q;
      end
    end
    if (ctl_i.do_fetch) begin
      last_q <= 1'b1;
      if (bad_c) begin
        st_q <= ST_NOT_RESIDENT;
        fr_q <= '0;
        vt_q <= '0;
        vp_q <= '0;
      end else if (hit_q) begin
        st_q <= ST_HIT;
        fr_q <= FrIdxW'(hit_idx_q);
        vt_q <= '0;
        vp_q <= '0;
      end else if (filled_q < lim_c) begin
        st_q <= ST_FILLED;
        fr_q <= FrIdxW'(filled_q);
        vt_q <= '0;
        vp_q <= '0;
      end else if (!vfound_q) begin
        st_q <= ST_ALL_PINNED;
        fr_q <= '0;
        vt_q <= '0;
        vp_q <= '0;
      end else if (dirty_q[vidx_q]) begin
        st_q <= ST_EVICT_DIRTY;
        fr_q <= FrIdxW'(vidx_q);
        vt_q <= tbl_q[vidx_q];
        vp_q <= page_q[vidx_q];
      end else begin
        st_q <= ST_EVICT_CLEAN;
        fr_q <= FrIdxW'(vidx_q);
        vt_q <= '0;
        vp_q <= '0;
      end
    end
    if (ctl_i.do_unpin) begin
      last_q <= 1'b1;
      vt_q <= '0;
      vp_q <= '0;
      st_q <= hit_q ? ST_UNPINNED : ST_NOT_RESIDENT;
      fr_q <= hit_q ? FrIdxW'(hit_idx_q) : '0;
    end
    if (ctl_i.emit_done) begin
      last_q <= 1'b1;
      st_q <= ST_DONE;
      fr_q <= '0;
      vt_q <= '0;
      vp_q <= '0;
    end
    if (ctl_i.walk_step) begin
      if (walk_sel && dirty_q[ptr_idx]) begin
        last_q <= 1'b0;
        st_q <= ST_WRITEBACK;
        fr_q <= FrIdxW'(ptr_idx);
        vt_q <= tbl_q[ptr_idx];
        vp_q <= page_q[ptr_idx];
      end else begin
        last_q <= 1'b1;
        st_q <= ST_DONE;
        fr_q <= '0;
        vt_q <= '0;
        vp_q <= '0;
      end
    end
  end

  assign result_valid_o = rv_q;
  assign status_o = st_q;
  assign frame_index_o = fr_q;
  assign victim_table_o = vt_q;
  assign victim_page_o = vp_q;
  assign last_result_o = last_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CntW'(Frames)) else $error("fill count overflow");
  a_onehot_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.match |-> $onehot0(match_c)) else $error("duplicate tag");
  a_fill_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q != $past(filled_q) |-> filled_q == $past(filled_q) + 1'b1)
    else $error("fill count jump");
`endif

endmodule

[verif/page_buffer_pool_lru_pin_unit_tb.sv]
`timescale 1ns / 1ps

module page_buffer_pool_lru_pin_unit_tb;
  import pbp_pkg::*;

  localparam int Frames = 32;
  localparam int MaxTables = 10;
  // A walk or an LRU scan touches every frame once, plus pipeline slack.
  localparam int DrainCycles = 48;
  // Cycles with no beat on any channel before the run is declared hung.
  localparam int StallLimit = 5000;

  typedef struct {
    status_e     status;
    logic [4:0]  frame;
    logic [3:0]  vtable;
    logic [31:0] vpage;
    logic        last;
  } pool_result_t;

  // One directed command; has_typed marks rows whose outcome is written out here.
  typedef struct {
    logic [2:0]  act;
    logic [3:0]  tbl;
    logic [31:0] pg;
    bit          has_typed;
    status_e     typed_status;
    logic [4:0]  typed_frame;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [ActW-1:0] action_i = '0;
  logic [TblW-1:0] table_ident_i = '0;
  logic [PageW-1:0] page_number_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic busy_o, result_valid_o, last_result_o, cfg_ready_o;
  logic [StatW-1:0] status_o;
  logic [FrIdxW-1:0] frame_index_o;
  logic [TblW-1:0] victim_table_o;
  logic [PageW-1:0] victim_page_o;

  always #5 clk_i = ~clk_i;

  page_buffer_pool_lru_pin_unit i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .action_i(action_i),
    .table_ident_i(table_ident_i),
    .page_number_i(page_number_i),
    .result_valid_o(result_valid_o),
    .status_o(status_o),
    .frame_index_o(frame_index_o),
    .victim_table_o(victim_table_o),
    .victim_page_o(victim_page_o),
    .last_result_o(last_result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the pool. Ranks are kept as ints because a freshly filled
  // frame briefly holds rank Frames, one past what five bits can carry.
  logic [5:0]  pool_limit;
  bit          pool_valid[Frames];
  logic [3:0]  pool_table[Frames];
  logic [31:0] pool_page[Frames];
  bit          pool_dirty[Frames];
  int          pool_pins[Frames];
  int          pool_rank[Frames];
  int          pool_filled;

  pool_result_t pending_results[$];
  int mismatches = 0;
  int idle_pct = 0;

  // Tags handed out by fetches, so unpins mostly aim at resident pages.
  logic [3:0]  seen_tbl[$];
  logic [31:0] seen_pg[$];

  function automatic void push_result(status_e st, int fr, logic [3:0] vt,
                                      logic [31:0] vp, bit last);
    pool_result_t r;
    r.status = st;
    r.frame = fr[4:0];
    r.vtable = vt;
    r.vpage = vp;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic int find_frame(logic [3:0] tbl, logic [31:0] pg);
    for (int i = 0; i < Frames; i++) begin
      if (pool_valid[i] && pool_table[i] == tbl && pool_page[i] == pg) return i;
    end
    return -1;
  endfunction

  function automatic void make_recent(int f);
    int r;
    r = pool_rank[f];
    for (int i = 0; i < Frames; i++) begin
      if (i != f && pool_valid[i] && pool_rank[i] < r) pool_rank[i]++;
    end
    pool_rank[f] = 0;
  endfunction

  function automatic void pool_reset();
    pool_limit = CfgReset;
    pool_filled = 0;
    for (int i = 0; i < Frames; i++) begin
      pool_valid[i] = 0;
      pool_table[i] = '0;
      pool_page[i] = '0;
      pool_dirty[i] = 0;
      pool_pins[i] = 0;
      pool_rank[i] = 0;
    end
  endfunction

  // Works out every result one command causes and updates the shadow pool.
  function automatic void predict_pool(logic [2:0] act, logic [3:0] tbl, logic [31:0] pg);
    int f;
    int lim;
    int victim;
    victim = -1;
    case (act)
      ACT_FETCH: begin
        if (tbl == 0 || tbl > MaxTables) begin
          push_result(ST_NOT_RESIDENT, 0, '0, '0, 1);
          return;
        end
        f = find_frame(tbl, pg);
        if (f >= 0) begin
          if (pool_pins[f] < PinMax) pool_pins[f]++;
          make_recent(f);
          push_result(ST_HIT, f, '0, '0, 1);
          return;
        end
        lim = pool_limit;
        if (lim < 1) lim = 1;
        if (lim > Frames) lim = Frames;
        if (pool_filled < lim) begin
          f = pool_filled;
          pool_filled++;
          pool_valid[f] = 1;
          pool_table[f] = tbl;
          pool_page[f] = pg;
          pool_dirty[f] = 0;
          pool_pins[f] = 1;
          pool_rank[f] = Frames;
          make_recent(f);
          push_result(ST_FILLED, f, '0, '0, 1);
          return;
        end
        // The victim is the oldest unpinned frame; ties go to the lowest index.
        for (int i = 0; i < Frames; i++) begin
          if (pool_valid[i] && pool_pins[i] == 0 &&
              (victim < 0 || pool_rank[i] > pool_rank[victim])) victim = i;
        end
        if (victim < 0) begin
          push_result(ST_ALL_PINNED, 0, '0, '0, 1);
          return;
        end
        if (pool_dirty[victim]) begin
          push_result(ST_EVICT_DIRTY, victim, pool_table[victim], pool_page[victim], 1);
        end else begin
          push_result(ST_EVICT_CLEAN, victim, '0, '0, 1);
        end
        pool_table[victim] = tbl;
        pool_page[victim] = pg;
        pool_dirty[victim] = 0;
        pool_pins[victim] = 1;
        make_recent(victim);
      end
      ACT_UNPIN, ACT_UNPIN_DIRTY: begin
        f = find_frame(tbl, pg);
        if (f < 0) begin
          push_result(ST_NOT_RESIDENT, 0, '0, '0, 1);
          return;
        end
        if (pool_pins[f] > 0) pool_pins[f]--;
        if (act == ACT_UNPIN_DIRTY) pool_dirty[f] = 1;
        push_result(ST_UNPINNED, f, '0, '0, 1);
      end
      ACT_CLOSE, ACT_FLUSH: begin
        for (int i = 0; i < Frames; i++) begin
          if (pool_valid[i] && (act == ACT_FLUSH || pool_table[i] == tbl)) begin
            if (pool_dirty[i]) begin
              push_result(ST_WRITEBACK, i, pool_table[i], pool_page[i], 0);
              pool_dirty[i] = 0;
            end
            if (act == ACT_CLOSE) pool_pins[i] = 0;
          end
        end
        push_result(ST_DONE, 0, '0, '0, 1);
      end
      default: push_result(ST_DONE, 0, '0, '0, 1);
    endcase
  endfunction

  // Drives one command beat and holds it until the block takes it. A random
  // gap may follow, during which start_i is low.
  task automatic send_cmd(logic [2:0] act, logic [3:0] tbl, logic [31:0] pg);
    start_i <= 1'b1;
    action_i <= act;
    table_ident_i <= tbl;
    page_number_i <= pg;
    do @(posedge clk_i); while (busy_o);
    predict_pool(act, tbl, pg);
    if (act == ACT_FETCH && tbl != 0 && tbl <= MaxTables) begin
      seen_tbl.push_back(tbl);
      seen_pg.push_back(pg);
      if (seen_tbl.size() > 40) begin
        void'(seen_tbl.pop_front());
        void'(seen_pg.pop_front());
      end
    end
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Lets every expected beat arrive, then waits out any walk still running.
  task automatic drain_pool();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [5:0] value);
    drain_pool();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pool_limit = value;
  endtask

  // Random command: mostly fetches and unpins over a small tag space so that
  // hits, evictions and write-backs are frequent; the rest is noise.
  task automatic send_random_cmd();
    int pick;
    int k;
    logic [3:0] tbl;
    logic [31:0] pg;
    pick = $urandom_range(99);
    tbl = 4'($urandom_range(1, 4));
    pg = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(7));
    if ($urandom_range(29) == 0) tbl = 4'($urandom_range(15));
    if (pick < 45) begin
      send_cmd(ACT_FETCH, tbl, pg);
    end else if (pick < 85) begin
      if (seen_tbl.size() != 0 && $urandom_range(9) != 0) begin
        k = $urandom_range(seen_tbl.size() - 1);
        tbl = seen_tbl[k];
        pg = seen_pg[k];
      end
      send_cmd(pick < 65 ? ACT_UNPIN : ACT_UNPIN_DIRTY, tbl, pg);
    end else if (pick < 92) begin
      send_cmd(ACT_CLOSE, tbl, 32'($urandom));
    end else if (pick < 97) begin
      send_cmd(ACT_FLUSH, 4'($urandom), 32'($urandom));
    end else begin
      send_cmd(3'($urandom_range(5, 7)), 4'($urandom), 32'($urandom));
    end
  endtask

  // Every strobed beat is accepted at the edge that ends its cycle, so it is
  // checked there against the oldest expectation.
  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result beat status=%0d frame=%0d", $realtime,
                   status_o, frame_index_o);
        end
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || frame_index_o !== want.frame ||
            victim_table_o !== want.vtable || victim_page_o !== want.vpage ||
            last_result_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch expected st=%0d fr=%0d vt=%0d vp=%h last=%0b",
                     $realtime, want.status, want.frame, want.vtable, want.vpage, want.last);
            $display("%0t:                   actual st=%0d fr=%0d vt=%0d vp=%h last=%0b",
                     $realtime, status_o, frame_index_o, victim_table_o, victim_page_o,
                     last_result_o);
          end
        end
      end
    end
  end

  // Hang detection: any beat on any channel restarts the count.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Directed commands. Rows with a typed outcome are single-beat results
  // that follow directly from the command; the rest take their outcome from the predictor.
  cmd_row_t directed[] = '{
    '{ACT_FETCH, 4'd1, 32'h0, 1, ST_FILLED, 5'd0},
    '{ACT_FETCH, 4'd10, 32'hFFFF_FFFF, 1, ST_FILLED, 5'd1},
    '{ACT_FETCH, 4'd0, 32'h5, 1, ST_NOT_RESIDENT, 5'd0},
    '{ACT_FETCH, 4'd11, 32'h5, 1, ST_NOT_RESIDENT, 5'd0},
    '{ACT_FETCH, 4'd15, 32'hA5A5_5A5A, 1, ST_NOT_RESIDENT, 5'd0},
    '{ACT_FETCH, 4'd1, 32'h0, 1, ST_HIT, 5'd0},
    '{ACT_UNPIN, 4'd1, 32'h0, 1, ST_UNPINNED, 5'd0},
    '{ACT_UNPIN, 4'd1, 32'h0, 1, ST_UNPINNED, 5'd0},
    '{ACT_UNPIN, 4'd1, 32'h0, 1, ST_UNPINNED, 5'd0},
    '{ACT_UNPIN_DIRTY, 4'd10, 32'hFFFF_FFFF, 1, ST_UNPINNED, 5'd1},
    '{ACT_UNPIN, 4'd3, 32'h7, 1, ST_NOT_RESIDENT, 5'd0},
    '{3'd5, 4'd1, 32'h0, 1, ST_DONE, 5'd0},
    '{3'd6, 4'd2, 32'h0, 1, ST_DONE, 5'd0},
    '{3'd7, 4'd15, 32'hFFFF_FFFF, 1, ST_DONE, 5'd0},
    '{ACT_FLUSH, 4'd0, 32'h0, 0, ST_DONE, 5'd0},
    '{ACT_UNPIN_DIRTY, 4'd1, 32'h0, 0, ST_DONE, 5'd0},
    '{ACT_UNPIN_DIRTY, 4'd10, 32'hFFFF_FFFF, 0, ST_DONE, 5'd0},
    '{ACT_CLOSE, 4'd1, 32'h0, 0, ST_DONE, 5'd0},
    '{ACT_CLOSE, 4'd2, 32'h0, 0, ST_DONE, 5'd0},
    '{ACT_FLUSH, 4'd15, 32'hFFFF_FFFF, 0, ST_DONE, 5'd0}
  };

  // Rows run with only one frame allowed: clean eviction, pinned pool, dirty eviction.
  // The two frames filled earlier stay resident, so both are pinned before the
  // all-pinned row.
  cmd_row_t tight[] = '{
    '{ACT_FETCH, 4'd2, 32'h1, 0, ST_DONE, 5'd0},
    '{ACT_FETCH, 4'd1, 32'h0, 0, ST_DONE, 5'd0},
    '{ACT_FETCH, 4'd2, 32'h2, 1, ST_ALL_PINNED, 5'd0},
    '{ACT_UNPIN_DIRTY, 4'd2, 32'h1, 0, ST_DONE, 5'd0},
    '{ACT_FETCH, 4'd3, 32'h3, 0, ST_DONE, 5'd0},
    '{ACT_CLOSE, 4'd10, 32'h0, 0, ST_DONE, 5'd0}
  };

  task automatic run_rows(cmd_row_t rows[]);
    int last_idx;
    foreach (rows[i]) begin
      send_cmd(rows[i].act, rows[i].tbl, rows[i].pg);
      // The typed outcome replaces the predicted beat; the shadow pool still advances.
      if (rows[i].has_typed) begin
        last_idx = pending_results.size() - 1;
        pending_results[last_idx].status = rows[i].typed_status;
        pending_results[last_idx].frame = rows[i].typed_frame;
      end
    end
  endtask

  logic [5:0] limits[] = '{6'd0, 6'd63, 6'd5, 6'd2, 6'd32, 6'd17};

  initial begin
    pool_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_rows(directed);
    write_limit(6'd1);
    run_rows(tight);

    // Hit one page until its pin count saturates, then release it by closing.
    write_limit(6'd63);
    for (int i = 0; i < 258; i++) send_cmd(ACT_FETCH, 4'd9, 32'h1234_5678);
    send_cmd(ACT_UNPIN, 4'd9, 32'h1234_5678);
    send_cmd(ACT_CLOSE, 4'd9, 32'h0);

    // Three idling phases: sparse gaps, dense gaps, then back to back.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 35 : (phase == 1) ? 76 : 0;
      for (int s = 0; s < 2; s++) begin
        write_limit(limits[phase * 2 + s]);
        for (int n = 0; n < 31; n++) send_random_cmd();
      end
    end

    drain_pool();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
